### src/odo_pkg.sv
package odo_pkg;

   localparam int unsigned SIZE_W     = 12;
   localparam int unsigned STRIDE_W   = 32;
   localparam int unsigned PROD_W     = SIZE_W + STRIDE_W;
   localparam int unsigned SRC_W      = 46;
   localparam int unsigned DST_W      = 48;
   localparam int unsigned REG_DIMS   = 4;
   localparam int unsigned MAX_RANK_DEFAULT = 4;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM1   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM2   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM3   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_DIM0 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_DIM1 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_DIM2 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_STRIDE_DIM3 = 3'd7;

   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 12'd1;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 32'd0;

   typedef struct packed {
      logic clear;    // restart: treat the held index as zero
      logic load;     // request accepted this cycle
      logic advance;  // step the odometer (request accepted, shape not empty)
   } cell_ctl_type;

endpackage

### src/odo_cell.sv
module odo_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  odo_pkg::cell_ctl_type             ctl,
   input  logic                              carry_in,
   input  logic [odo_pkg::SIZE_W-1:0]        dim_size,
   input  logic [odo_pkg::STRIDE_W-1:0]      dim_stride,
   output logic                              carry_out,
   output logic [odo_pkg::PROD_W-1:0]        prod
);

   logic [odo_pkg::SIZE_W-1:0] idx_ff;
   logic [odo_pkg::SIZE_W-1:0] idx_in;
   logic [odo_pkg::SIZE_W-1:0] idx_cur;
   logic [odo_pkg::SIZE_W:0]   idx_next;
   logic                       wrap;
   logic [odo_pkg::PROD_W-1:0] prod_ff;
   logic [odo_pkg::PROD_W-1:0] prod_in;

   assign idx_cur   = ctl.clear ? '0 : idx_ff;
   assign idx_next  = {1'b0, idx_cur} + {{odo_pkg::SIZE_W{1'b0}}, 1'b1};
   // an index at or past a shrunken size wraps as well
   assign wrap      = idx_next >= {1'b0, dim_size};
   assign carry_out = carry_in & wrap;

   always_comb begin
      idx_in = idx_ff;
      if (ctl.load) begin
         if (ctl.advance && carry_in) begin
            idx_in = wrap ? '0 : idx_next[odo_pkg::SIZE_W-1:0];
         end else begin
            idx_in = idx_cur;
         end
      end
   end

   assign prod_in = odo_pkg::PROD_W'(idx_cur) * odo_pkg::PROD_W'(dim_stride);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### src/strided_odometer_address_gen.sv
// Throughput: one request per cycle while the output is not stalled (rsp_stall);
// the odometer carry ripples combinationally through the row of dimension cells,
// and the index-times-stride products are registered in each cell before a
// combinational sum into the output register.
// Reset (synchronous) clears all indices and the linear count, empties the
// pipeline, and sets every size register to 1 and every stride register to 0.
module strided_odometer_address_gen #(
   parameter int unsigned MAX_RANK = odo_pkg::MAX_RANK_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [odo_pkg::SRC_W-1:0]           rsp_src_offset,
   output logic [odo_pkg::DST_W-1:0]           rsp_dst_index,
   output logic                                rsp_last,
   output logic                                rsp_empty_res,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [odo_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [odo_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [odo_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned SW = odo_pkg::SIZE_W;
   localparam int unsigned TW = odo_pkg::STRIDE_W;

   // configuration registers
   logic [SW-1:0] size_ff   [odo_pkg::REG_DIMS];
   logic [TW-1:0] stride_ff [odo_pkg::REG_DIMS];

   logic                            csr_wr;
   logic [odo_pkg::REG_IDX_W-1:0]   csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[odo_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < odo_pkg::REG_DIMS; i++) begin
            size_ff[i]   <= odo_pkg::SIZE_RESET;
            stride_ff[i] <= odo_pkg::STRIDE_RESET;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            odo_pkg::REG_SIZE_DIM0:   size_ff[0]   <= csr_pwdata[SW-1:0];
            odo_pkg::REG_SIZE_DIM1:   size_ff[1]   <= csr_pwdata[SW-1:0];
            odo_pkg::REG_SIZE_DIM2:   size_ff[2]   <= csr_pwdata[SW-1:0];
            odo_pkg::REG_SIZE_DIM3:   size_ff[3]   <= csr_pwdata[SW-1:0];
            odo_pkg::REG_STRIDE_DIM0: stride_ff[0] <= csr_pwdata;
            odo_pkg::REG_STRIDE_DIM1: stride_ff[1] <= csr_pwdata;
            odo_pkg::REG_STRIDE_DIM2: stride_ff[2] <= csr_pwdata;
            odo_pkg::REG_STRIDE_DIM3: stride_ff[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         odo_pkg::REG_SIZE_DIM0:   csr_prdata = odo_pkg::CSR_DATA_W'(size_ff[0]);
         odo_pkg::REG_SIZE_DIM1:   csr_prdata = odo_pkg::CSR_DATA_W'(size_ff[1]);
         odo_pkg::REG_SIZE_DIM2:   csr_prdata = odo_pkg::CSR_DATA_W'(size_ff[2]);
         odo_pkg::REG_SIZE_DIM3:   csr_prdata = odo_pkg::CSR_DATA_W'(size_ff[3]);
         odo_pkg::REG_STRIDE_DIM0: csr_prdata = stride_ff[0];
         odo_pkg::REG_STRIDE_DIM1: csr_prdata = stride_ff[1];
         odo_pkg::REG_STRIDE_DIM2: csr_prdata = stride_ff[2];
         odo_pkg::REG_STRIDE_DIM3: csr_prdata = stride_ff[3];
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_en, s1_en, accept;

   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // empty shape check over the active dimensions
   logic empty;
   always_comb begin
      empty = 1'b0;
      for (int d = 0; d < MAX_RANK && d < odo_pkg::REG_DIMS; d++) begin
         if (size_ff[d] == '0) begin
            empty = 1'b1;
         end
      end
   end

   odo_pkg::cell_ctl_type cell_ctl;
   assign cell_ctl.clear   = req_restart;
   assign cell_ctl.load    = accept;
   assign cell_ctl.advance = accept && !empty;

   // carry enters at the innermost cell and ripples left
   logic                        carry [MAX_RANK+1];
   logic [odo_pkg::PROD_W-1:0]  prod  [MAX_RANK];

   assign carry[MAX_RANK] = 1'b1;

   for (genvar d = 0; d < MAX_RANK; d++) begin : g_cell
      logic [SW-1:0] cell_size;
      logic [TW-1:0] cell_stride;
      if (d < odo_pkg::REG_DIMS) begin : g_reg
         assign cell_size   = size_ff[d];
         assign cell_stride = stride_ff[d];
      end else begin : g_pad
         assign cell_size   = SW'(1);
         assign cell_stride = '0;
      end
      odo_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .carry_in   (carry[d+1]),
         .dim_size   (cell_size),
         .dim_stride (cell_stride),
         .carry_out  (carry[d]),
         .prod       (prod[d])
      );
   end

   // linear count
   logic [odo_pkg::DST_W-1:0] lin_ff, lin_in, lin_cur;
   assign lin_cur = req_restart ? '0 : lin_ff;

   always_comb begin
      lin_in = lin_ff;
      if (accept) begin
         if (empty) begin
            lin_in = lin_cur;
         end else if (carry[0]) begin
            lin_in = '0;
         end else begin
            lin_in = lin_cur + odo_pkg::DST_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff <= '0;
      end else begin
         lin_ff <= lin_in;
      end
   end

   // stage 1: products sit in the cells, side data here
   logic                      s1_empty_ff, s1_last_ff;
   logic [odo_pkg::DST_W-1:0] s1_dst_ff;

   assign s1_valid_in = s1_en ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_empty_ff <= empty;
         s1_last_ff  <= empty || carry[0];
         s1_dst_ff   <= lin_cur;
      end
   end

   logic [odo_pkg::SRC_W-1:0] sum;
   always_comb begin
      sum = '0;
      for (int d = 0; d < MAX_RANK; d++) begin
         sum = sum + odo_pkg::SRC_W'(prod[d]);
      end
   end

   // output register
   logic [odo_pkg::SRC_W-1:0] src_ff;
   logic [odo_pkg::DST_W-1:0] dst_ff;
   logic                      last_ff, empty_ff;

   assign out_valid_in = out_en ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         src_ff   <= s1_empty_ff ? '0 : sum;
         dst_ff   <= s1_empty_ff ? '0 : s1_dst_ff;
         last_ff  <= s1_last_ff;
         empty_ff <= s1_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_src_offset = src_ff;
   assign rsp_dst_index  = dst_ff;
   assign rsp_last       = last_ff;
   assign rsp_empty_res  = empty_ff;

endmodule

### src/odo_checker.sv
module odo_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [odo_pkg::SRC_W-1:0]           rsp_src_offset,
   input logic [odo_pkg::DST_W-1:0]           rsp_dst_index,
   input logic                                rsp_last,
   input logic                                rsp_empty_res
);

   // an empty shape reports a zero address that also ends the traversal
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
         rsp_last && rsp_src_offset == '0 && rsp_dst_index == '0)
      else $error("empty result with nonzero payload or last clear");

   // requests are held back only while a result is waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no pending result");

   // pipeline comes up empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_src_offset)
         && $stable(rsp_dst_index) && $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("stalled result changed");

endmodule

bind strided_odometer_address_gen odo_checker u_odo_checker (.*);
